[rtl/core/lcd4ws_pkg.sv]
// Shared types, codes and constants for the 4-bit character LCD write sequencer.
// No dependencies; used by the top level and its testbench.
`timescale 1ns / 1ps
`default_nettype none

package lcd4ws_pkg;

  localparam int unsigned WAIT_BITS_DEFAULT = 20;

  // Configuration register resets
  localparam logic [19:0] POWERUP_WAIT_RST  = 20'd100000;
  localparam logic [15:0] NIBBLE_WAIT_RST   = 16'd5000;
  localparam logic [15:0] COMMAND_WAIT_RST  = 16'd50;
  localparam logic [15:0] CLEAR_WAIT_RST    = 16'd2000;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_INIT   = 2'd1,
    CMD_NIBBLE = 2'd2,
    CMD_BYTE   = 2'd3
  } command_e;

  typedef enum logic [1:0] {
    REG_POWERUP_WAIT = 2'd0,
    REG_NIBBLE_WAIT  = 2'd1,
    REG_COMMAND_WAIT = 2'd2,
    REG_CLEAR_WAIT   = 2'd3
  } reg_index_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_POWERUP = 4'b0010,
    PH_EHIGH   = 4'b0100,
    PH_WAIT    = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    WS_NIBBLE  = 2'd0,
    WS_COMMAND = 2'd1,
    WS_CLEAR   = 2'd2
  } wait_sel_e;

  typedef struct packed {
    logic      is_byte;
    logic [7:0] value;
    wait_sel_e wsel;
  } init_item_t;

  // Power-on init script: three 0x3 nibbles, one 0x2 nibble, then
  // function set, display on, cursor shift and clear display bytes.
  function automatic init_item_t init_item(input logic [2:0] k);
    init_item_t it;
    unique case (k)
      3'd0, 3'd1, 3'd2: it = '{is_byte: 1'b0, value: 8'h03, wsel: WS_NIBBLE};
      3'd3:             it = '{is_byte: 1'b0, value: 8'h02, wsel: WS_NIBBLE};
      3'd4:             it = '{is_byte: 1'b1, value: 8'h28, wsel: WS_COMMAND};
      3'd5:             it = '{is_byte: 1'b1, value: 8'h0c, wsel: WS_COMMAND};
      3'd6:             it = '{is_byte: 1'b1, value: 8'h14, wsel: WS_COMMAND};
      default:          it = '{is_byte: 1'b1, value: 8'h01, wsel: WS_CLEAR};
    endcase
    return it;
  endfunction

endpackage

`default_nettype wire

[rtl/core/lcd_4bit_write_sequencer_top.sv]
// A result appears on the output register in the cycle after its transaction is taken.
// Throughput: one transaction per cycle; a tick is one step of the wait counter and phase FSM.
// The input side stalls only while a result is held by a stalled output register.
// Reset: phase idle, counters and pins low, registers at their default waits.
// No memories, so no clearing pass after reset.
// Depends on lcd4ws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcd_4bit_write_sequencer_top #(
  parameter int unsigned WAIT_BITS = lcd4ws_pkg::WAIT_BITS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic        register_select_i,
  input  wire logic [15:0] post_wait_us_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       lcd_data_o,
  output logic             lcd_enable_o,
  output logic             lcd_rs_o,
  output logic             busy_res_o,
  output logic             accepted_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------- configuration registers ----------------
  logic [19:0] powerup_wait_q;
  logic [15:0] nibble_wait_q, command_wait_q, clear_wait_q;
  logic        cfg_wr;
  lcd4ws_pkg::reg_index_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = lcd4ws_pkg::reg_index_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      powerup_wait_q <= lcd4ws_pkg::POWERUP_WAIT_RST;
      nibble_wait_q  <= lcd4ws_pkg::NIBBLE_WAIT_RST;
      command_wait_q <= lcd4ws_pkg::COMMAND_WAIT_RST;
      clear_wait_q   <= lcd4ws_pkg::CLEAR_WAIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lcd4ws_pkg::REG_POWERUP_WAIT: powerup_wait_q <= pwdata[19:0];
        lcd4ws_pkg::REG_NIBBLE_WAIT:  nibble_wait_q  <= pwdata[15:0];
        lcd4ws_pkg::REG_COMMAND_WAIT: command_wait_q <= pwdata[15:0];
        default:                      clear_wait_q   <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lcd4ws_pkg::REG_POWERUP_WAIT: prdata = 32'(powerup_wait_q);
      lcd4ws_pkg::REG_NIBBLE_WAIT:  prdata = 32'(nibble_wait_q);
      lcd4ws_pkg::REG_COMMAND_WAIT: prdata = 32'(command_wait_q);
      default:                      prdata = 32'(clear_wait_q);
    endcase
  end

  // ---------------- handshake ----------------
  logic in_fire;
  logic out_valid_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  // ---------------- sequencer state ----------------
  lcd4ws_pkg::phase_e   phase_q, phase_d;
  logic [WAIT_BITS-1:0] wait_count_q, wait_count_d;
  logic [3:0]           init_step_q, init_step_d;
  logic [7:0]           held_byte_q, held_byte_d;
  logic                 held_rs_q, held_rs_d;
  logic [15:0]          held_wait_q, held_wait_d;
  logic                 low_pending_q, low_pending_d;
  logic [3:0]           pin_data_q, pin_data_d;
  logic                 pin_en_q, pin_en_d;
  logic                 pin_rs_q, pin_rs_d;
  logic                 acc;

  logic [WAIT_BITS-1:0] ehigh_wait, wait_dec, powerup_masked;
  logic                 idle_now;
  logic                 go_init, finish;
  logic [2:0]           init_k;
  lcd4ws_pkg::init_item_t item;
  logic [15:0]          item_wait;

  assign ehigh_wait     = low_pending_q ? WAIT_BITS'(1) : WAIT_BITS'(held_wait_q);
  assign wait_dec       = (wait_count_q != '0) ? wait_count_q - WAIT_BITS'(1) : '0;
  assign powerup_masked = WAIT_BITS'(powerup_wait_q);
  assign idle_now       = !(phase_q == lcd4ws_pkg::PH_POWERUP ||
                            phase_q == lcd4ws_pkg::PH_EHIGH ||
                            phase_q == lcd4ws_pkg::PH_WAIT);

  assign item = lcd4ws_pkg::init_item(init_k);
  always_comb begin
    unique case (item.wsel)
      lcd4ws_pkg::WS_NIBBLE:  item_wait = nibble_wait_q;
      lcd4ws_pkg::WS_COMMAND: item_wait = command_wait_q;
      default:                item_wait = clear_wait_q;
    endcase
  end

  always_comb begin
    phase_d       = phase_q;
    wait_count_d  = wait_count_q;
    init_step_d   = init_step_q;
    held_byte_d   = held_byte_q;
    held_rs_d     = held_rs_q;
    held_wait_d   = held_wait_q;
    low_pending_d = low_pending_q;
    pin_data_d    = pin_data_q;
    pin_en_d      = pin_en_q;
    pin_rs_d      = pin_rs_q;
    acc           = 1'b0;
    go_init       = 1'b0;
    finish        = 1'b0;
    init_k        = '0;

    if (lcd4ws_pkg::command_e'(command_i) == lcd4ws_pkg::CMD_TICK) begin
      unique case (phase_q)
        lcd4ws_pkg::PH_POWERUP: begin
          if (wait_count_q > WAIT_BITS'(1)) begin
            wait_count_d = wait_count_q - WAIT_BITS'(1);
          end else begin
            wait_count_d = '0;
            go_init      = 1'b1;
          end
        end
        lcd4ws_pkg::PH_EHIGH: begin
          pin_en_d     = 1'b0;
          wait_count_d = ehigh_wait;
          phase_d      = lcd4ws_pkg::PH_WAIT;
          finish       = (ehigh_wait == '0);
        end
        lcd4ws_pkg::PH_WAIT: begin
          wait_count_d = wait_dec;
          finish       = (wait_dec == '0);
        end
        default: phase_d = lcd4ws_pkg::PH_IDLE;
      endcase
    end else if (idle_now) begin
      acc = 1'b1;
      unique case (lcd4ws_pkg::command_e'(command_i))
        lcd4ws_pkg::CMD_INIT: begin
          wait_count_d = powerup_masked;
          if (powerup_masked == '0) begin
            go_init = 1'b1;
          end else begin
            init_step_d = '0;
            phase_d     = lcd4ws_pkg::PH_POWERUP;
          end
        end
        lcd4ws_pkg::CMD_NIBBLE: begin
          init_step_d   = '0;
          held_rs_d     = register_select_i;
          held_wait_d   = post_wait_us_i;
          low_pending_d = 1'b0;
          pin_data_d    = byte_value_i[3:0];
          pin_en_d      = 1'b1;
          pin_rs_d      = register_select_i;
          phase_d       = lcd4ws_pkg::PH_EHIGH;
        end
        default: begin
          init_step_d   = '0;
          held_byte_d   = byte_value_i;
          held_rs_d     = register_select_i;
          held_wait_d   = post_wait_us_i;
          low_pending_d = 1'b1;
          pin_data_d    = byte_value_i[7:4];
          pin_en_d      = 1'b1;
          pin_rs_d      = register_select_i;
          phase_d       = lcd4ws_pkg::PH_EHIGH;
        end
      endcase
    end

    // end of a nibble's wait: low nibble, next init item, or done
    if (finish) begin
      if (low_pending_q) begin
        low_pending_d = 1'b0;
        pin_data_d    = held_byte_q[3:0];
        pin_en_d      = 1'b1;
        pin_rs_d      = held_rs_q;
        phase_d       = lcd4ws_pkg::PH_EHIGH;
      end else if (init_step_q != '0 && !init_step_q[3]) begin
        go_init = 1'b1;
        init_k  = init_step_q[2:0];
      end else begin
        init_step_d = '0;
        phase_d     = lcd4ws_pkg::PH_IDLE;
      end
    end

    if (go_init) begin
      init_step_d   = 4'({1'b0, init_k}) + 4'd1;
      held_rs_d     = 1'b0;
      held_wait_d   = item_wait;
      low_pending_d = item.is_byte;
      if (item.is_byte) begin
        held_byte_d = item.value;
      end
      pin_data_d    = item.is_byte ? item.value[7:4] : item.value[3:0];
      pin_en_d      = 1'b1;
      pin_rs_d      = 1'b0;
      phase_d       = lcd4ws_pkg::PH_EHIGH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= lcd4ws_pkg::PH_IDLE;
      wait_count_q  <= '0;
      init_step_q   <= '0;
      held_byte_q   <= '0;
      held_rs_q     <= 1'b0;
      held_wait_q   <= '0;
      low_pending_q <= 1'b0;
      pin_data_q    <= '0;
      pin_en_q      <= 1'b0;
      pin_rs_q      <= 1'b0;
    end else if (in_fire) begin
      phase_q       <= phase_d;
      wait_count_q  <= wait_count_d;
      init_step_q   <= init_step_d;
      held_byte_q   <= held_byte_d;
      held_rs_q     <= held_rs_d;
      held_wait_q   <= held_wait_d;
      low_pending_q <= low_pending_d;
      pin_data_q    <= pin_data_d;
      pin_en_q      <= pin_en_d;
      pin_rs_q      <= pin_rs_d;
    end
  end

  // ---------------- result register ----------------
  logic [3:0] lcd_data_q;
  logic       lcd_enable_q, lcd_rs_q, busy_q, accepted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      lcd_data_q   <= pin_data_d;
      lcd_enable_q <= pin_en_d;
      lcd_rs_q     <= pin_rs_d;
      busy_q       <= (phase_d != lcd4ws_pkg::PH_IDLE);
      accepted_q   <= acc;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign lcd_data_o   = lcd_data_q;
  assign lcd_enable_o = lcd_enable_q;
  assign lcd_rs_o     = lcd_rs_q;
  assign busy_res_o   = busy_q;
  assign accepted_o   = accepted_q;

endmodule

`default_nettype wire

[rtl/core/lcd4ws_checker.sv]
// Port-level assertions for the LCD write sequencer, bound to the top level.
// Depends on lcd_4bit_write_sequencer_top.
`timescale 1ns / 1ps
`default_nettype none

module lcd4ws_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [3:0] lcd_data_o,
  input wire logic       lcd_enable_o,
  input wire logic       lcd_rs_o,
  input wire logic       busy_res_o,
  input wire logic       accepted_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(lcd_data_o) &&
      $stable(lcd_enable_o) && $stable(lcd_rs_o) && $stable(busy_res_o) &&
      $stable(accepted_o))
    else $error("stalled result changed");

  // every taken transaction shows up as a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("transaction produced no result");

  // a taken request always leaves the sequencer busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> busy_res_o)
    else $error("accepted request but not busy");

  // E is only high during a nibble pulse
  a_enable_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lcd_enable_o |-> busy_res_o)
    else $error("enable high while idle");

endmodule

bind lcd_4bit_write_sequencer_top lcd4ws_checker u_lcd4ws_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .lcd_data_o   (lcd_data_o),
  .lcd_enable_o (lcd_enable_o),
  .lcd_rs_o     (lcd_rs_o),
  .busy_res_o   (busy_res_o),
  .accepted_o   (accepted_o)
);

`default_nettype wire

[tb/lcd_4bit_write_sequencer_top_tb.sv]
// Testbench for lcd_4bit_write_sequencer_top: drives requests and ticks, tracks the LCD pin
// levels with a cycle-free model of the sequencer and checks every result transaction.
// Depends on lcd4ws_pkg and the top level RTL.
`timescale 1ns / 1ps

import lcd4ws_pkg::*;

typedef struct packed {
  logic [3:0] data;
  logic       en;
  logic       rs;
  logic       busy;
  logic       acc;
} lcd_pins_t;

class lcd_seq_scoreboard;
  logic [19:0] powerup_us;
  logic [15:0] nibble_us, command_us, clear_us;

  phase_e      ph;
  logic [19:0] count;
  logic [3:0]  step;       // 0: no init running, else init item in flight
  logic [7:0]  byte_q;
  logic        rs_q;
  logic [15:0] wait_q;
  logic        low_pend;
  logic [3:0]  pin_data;
  logic        pin_e, pin_rs;

  lcd_pins_t   pins_q[$];
  int          n_fail;

  function new();
    powerup_us = POWERUP_WAIT_RST;
    nibble_us  = NIBBLE_WAIT_RST;
    command_us = COMMAND_WAIT_RST;
    clear_us   = CLEAR_WAIT_RST;
    ph         = PH_IDLE;
    count      = '0;
    step       = '0;
    byte_q     = '0;
    rs_q       = 1'b0;
    wait_q     = '0;
    low_pend   = 1'b0;
    pin_data   = '0;
    pin_e      = 1'b0;
    pin_rs     = 1'b0;
    n_fail     = 0;
  endfunction

  function void report(string msg);
    if (n_fail < 10) $display("%0t: %s", $time, msg);
    n_fail++;
  endfunction

  function void set_reg(reg_index_e idx, logic [31:0] v);
    case (idx)
      REG_POWERUP_WAIT: powerup_us = v[19:0];
      REG_NIBBLE_WAIT:  nibble_us  = v[15:0];
      REG_COMMAND_WAIT: command_us = v[15:0];
      default:          clear_us   = v[15:0];
    endcase
  endfunction

  function logic [31:0] reg_value(reg_index_e idx);
    case (idx)
      REG_POWERUP_WAIT: return {12'd0, powerup_us};
      REG_NIBBLE_WAIT:  return {16'd0, nibble_us};
      REG_COMMAND_WAIT: return {16'd0, command_us};
      default:          return {16'd0, clear_us};
    endcase
  endfunction

  function bit busy();
    return ph != PH_IDLE;
  endfunction

  function int pending();
    return pins_q.size();
  endfunction

  function void raise_e(logic [3:0] nib);
    pin_data = nib;
    pin_e    = 1'b1;
    pin_rs   = rs_q;
    ph       = PH_EHIGH;
  endfunction

  function void load_nibble(logic [3:0] nib, logic rs, logic [15:0] w);
    rs_q     = rs;
    wait_q   = w;
    low_pend = 1'b0;
    raise_e(nib);
  endfunction

  function void load_byte(logic [7:0] b, logic rs, logic [15:0] w);
    byte_q   = b;
    rs_q     = rs;
    wait_q   = w;
    low_pend = 1'b1;
    raise_e(b[7:4]);
  endfunction

  function void init_item(int k);
    step = 4'(k + 1);
    if (k < 3)       load_nibble(4'h3, 1'b0, nibble_us);
    else if (k == 3) load_nibble(4'h2, 1'b0, nibble_us);
    else if (k == 4) load_byte(8'h28, 1'b0, command_us);
    else if (k == 5) load_byte(8'h0c, 1'b0, command_us);
    else if (k == 6) load_byte(8'h14, 1'b0, command_us);
    else             load_byte(8'h01, 1'b0, clear_us);
  endfunction

  function void nibble_done();
    if (low_pend) begin
      low_pend = 1'b0;
      raise_e(byte_q[3:0]);
    end else if (step >= 1 && step <= 7) begin
      init_item(int'(step));
    end else begin
      step = '0;
      ph   = PH_IDLE;
    end
  endfunction

  function void tick();
    case (ph)
      PH_POWERUP: begin
        if (count > 1) count--;
        else begin
          count = '0;
          init_item(0);
        end
      end
      PH_EHIGH: begin
        pin_e = 1'b0;
        // the high nibble of a byte always gets a 1 us gap
        count = low_pend ? 20'd1 : {4'd0, wait_q};
        ph    = PH_WAIT;
        if (count == 0) nibble_done();
      end
      PH_WAIT: begin
        if (count > 0) count--;
        if (count == 0) nibble_done();
      end
      default: ;
    endcase
  endfunction

  function void note_input(command_e cmd, logic [7:0] b, logic rs, logic [15:0] w);
    lcd_pins_t r;
    r.acc = 1'b0;
    if (cmd == CMD_TICK) begin
      tick();
    end else if (ph == PH_IDLE) begin
      r.acc = 1'b1;
      case (cmd)
        CMD_INIT: begin
          count = powerup_us;
          if (count == 0) init_item(0);
          else begin
            step = '0;
            ph   = PH_POWERUP;
          end
        end
        CMD_NIBBLE: begin
          step = '0;
          load_nibble(b[3:0], rs, w);
        end
        default: begin
          step = '0;
          load_byte(b, rs, w);
        end
      endcase
    end
    r.data = pin_data;
    r.en   = pin_e;
    r.rs   = pin_rs;
    r.busy = (ph != PH_IDLE);
    pins_q.push_back(r);
  endfunction

  function void check_result(lcd_pins_t got);
    lcd_pins_t exp;
    if (pins_q.size() == 0) begin
      report($sformatf("unexpected result transaction data=%h e=%b rs=%b busy=%b acc=%b",
                       got.data, got.en, got.rs, got.busy, got.acc));
      return;
    end
    exp = pins_q.pop_front();
    if (got.data !== exp.data || got.en !== exp.en || got.rs !== exp.rs ||
        got.busy !== exp.busy || got.acc !== exp.acc)
      report($sformatf({"mismatch: expected data=%h e=%b rs=%b busy=%b acc=%b,",
                        " got data=%h e=%b rs=%b busy=%b acc=%b"},
                       exp.data, exp.en, exp.rs, exp.busy, exp.acc,
                       got.data, got.en, got.rs, got.busy, got.acc));
  endfunction
endclass

module lcd_4bit_write_sequencer_top_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  command_e    command_i;
  logic [7:0]  byte_value_i;
  logic        register_select_i;
  logic [15:0] post_wait_us_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  lcd_data_o;
  logic        lcd_enable_o;
  logic        lcd_rs_o;
  logic        busy_res_o;
  logic        accepted_o;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bit                quiet = 1'b0;  // no idling on either side while set
  lcd_seq_scoreboard sb;

  lcd_4bit_write_sequencer_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .byte_value_i      (byte_value_i),
    .register_select_i (register_select_i),
    .post_wait_us_i    (post_wait_us_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .lcd_data_o        (lcd_data_o),
    .lcd_enable_o      (lcd_enable_o),
    .lcd_rs_o          (lcd_rs_o),
    .busy_res_o        (busy_res_o),
    .accepted_o        (accepted_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 36);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{lcd_data_o, lcd_enable_o, lcd_rs_o, busy_res_o, accepted_o});
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(command_e cmd, logic [7:0] b, logic r, logic [15:0] w);
    while (!quiet && $urandom_range(99) < 36) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        = 1'b1;
    command_i         = cmd;
    byte_value_i      = b;
    register_select_i = r;
    post_wait_us_i    = w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(cmd, b, r, w);
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
              16'($urandom_range(65535)));
  endtask

  // A request of random kind and payload, sent while busy so that it is turned away.
  task automatic send_reject();
    send_item(command_e'($urandom_range(3, 1)), 8'($urandom_range(255)),
              1'($urandom_range(1)), 16'($urandom_range(65535)));
  endtask

  // Tick the sequencer back to idle and let every result drain.
  task automatic settle();
    while (sb.busy()) send_tick();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic read_reg(reg_index_e idx);
    logic [31:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== sb.reg_value(idx))
      sb.report($sformatf("register %s read back %h, expected %h",
                          idx.name(), got, sb.reg_value(idx)));
  endtask

  task automatic write_reg(reg_index_e idx, logic [31:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    read_reg(idx);
  endtask

  task automatic set_waits(logic [19:0] pu, logic [15:0] nib, logic [15:0] cmd,
                           logic [15:0] clr);
    settle();
    write_reg(REG_POWERUP_WAIT, {12'd0, pu});
    write_reg(REG_NIBBLE_WAIT, {16'd0, nib});
    write_reg(REG_COMMAND_WAIT, {16'd0, cmd});
    write_reg(REG_CLEAR_WAIT, {16'd0, clr});
  endtask

  function automatic logic [15:0] pick_wait();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(3));
    if (r < 97) return 16'($urandom_range(20, 4));
    return 16'($urandom_range(300));
  endfunction

  initial begin
    int r;
    int n_items;
    sb                = new();
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    command_i         = CMD_TICK;
    byte_value_i      = '0;
    register_select_i = 1'b0;
    post_wait_us_i    = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // defaults after reset
    read_reg(REG_POWERUP_WAIT);
    read_reg(REG_NIBBLE_WAIT);
    read_reg(REG_COMMAND_WAIT);
    read_reg(REG_CLEAR_WAIT);

    // Top values everywhere; no init runs here, init would take seconds.
    set_waits(20'hfffff, 16'hffff, 16'hffff, 16'hffff);
    send_item(CMD_TICK, 8'hff, 1'b1, 16'hffff);      // tick while idle
    send_item(CMD_NIBBLE, 8'hff, 1'b1, 16'h0000);    // zero post wait
    send_tick();
    send_item(CMD_BYTE, 8'ha5, 1'b0, 16'h0000);
    send_item(CMD_INIT, 8'h00, 1'b0, 16'h0000);      // rejected while busy
    send_item(CMD_NIBBLE, 8'h3c, 1'b1, 16'h0001);
    send_item(CMD_BYTE, 8'hff, 1'b1, 16'h0010);
    settle();
    send_item(CMD_BYTE, 8'h5a, 1'b1, 16'h0003);
    send_tick();
    send_reject();
    settle();
    send_item(CMD_NIBBLE, 8'hf0, 1'b0, 16'h0002);    // only the low nibble matters
    settle();
    send_item(CMD_BYTE, 8'h00, 1'b0, 16'h0001);
    settle();
    // long post wait, run through at full rate
    quiet = 1'b1;
    send_item(CMD_NIBBLE, 8'h5f, 1'b1, 16'h0040);
    settle();
    quiet = 1'b0;

    // all waits zero: init starts its first nibble with the request
    set_waits(20'd0, 16'd0, 16'd0, 16'd0);
    send_item(CMD_INIT, 8'hff, 1'b1, 16'hffff);
    send_reject();
    settle();
    send_item(CMD_BYTE, 8'h81, 1'b1, 16'h0000);
    settle();

    set_waits(20'd1, 16'd1, 16'd2, 16'd3);
    send_item(CMD_INIT, 8'h00, 1'b0, 16'h0000);
    send_tick();
    send_reject();
    send_reject();
    settle();

    for (int phase_n = 0; phase_n < 5; phase_n++) begin
      case (phase_n)
        0: set_waits(20'd1, 16'd0, 16'd0, 16'd0);
        2: set_waits(20'd0, 16'd0, 16'd0, 16'd0);
        4: set_waits(20'd200, 16'd20, 16'd7, 16'd30);
        default: set_waits(20'($urandom_range(6)), 16'($urandom_range(4)),
                           16'($urandom_range(3)), 16'($urandom_range(5)));
      endcase
      quiet   = (phase_n == 2);
      n_items = 0;
      while (n_items < 110) begin
        r = $urandom_range(99);
        if (!sb.busy()) begin
          if (r < 15)
            send_item(CMD_INIT, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      16'($urandom_range(65535)));
          else if (r < 50)
            send_item(CMD_NIBBLE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      pick_wait());
          else if (r < 90)
            send_item(CMD_BYTE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                      pick_wait());
          else
            send_tick();
          if (r < 90) n_items++;
        end else begin
          if (r < 12) send_reject();
          else send_tick();
          n_items++;
        end
      end
    end
    quiet = 1'b0;

    settle();
    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("results still outstanding at end of run");
    if (sb.n_fail == 0) begin
      $display("lcd_4bit_write_sequencer_top test passed");
    end else begin
      $display("lcd_4bit_write_sequencer_top test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("lcd_4bit_write_sequencer_top test failed");
    $finish;
  end

endmodule
